>>> design/roi_pkg.sv
// shared constants, codes and result type of the rebase opcode interpreter
package roi_pkg;

  localparam int unsigned SEGMENTS      = 4;
  localparam int unsigned POINTER_BYTES = 8;
  localparam int unsigned SEG_SLOTS     = 4;
  localparam int unsigned QDEPTH        = 3;

  localparam logic [63:0] PREFERRED_BASE = 64'h0000_0001_0000_0000;
  localparam logic [63:0] COUNT_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] PTR_BYTES_W    = 64'(POINTER_BYTES);
  localparam logic [2:0]  SEG_CAP        = 3'((SEGMENTS < SEG_SLOTS) ? SEGMENTS : SEG_SLOTS);

  // opcodes
  localparam logic [3:0] OP_DONE        = 4'd0;
  localparam logic [3:0] OP_SET_KIND    = 4'd1;
  localparam logic [3:0] OP_SET_SEG     = 4'd2;
  localparam logic [3:0] OP_ADD_ULEB    = 4'd3;
  localparam logic [3:0] OP_ADD_IMM     = 4'd4;
  localparam logic [3:0] OP_RUN_IMM     = 4'd5;
  localparam logic [3:0] OP_RUN_ULEB    = 4'd6;
  localparam logic [3:0] OP_RUN_ADD     = 4'd7;
  localparam logic [3:0] OP_RUN_SKIP    = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_RUN    = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // pointer kinds
  localparam logic [3:0] PK_PLAIN = 4'd1;
  localparam logic [3:0] PK_ABS32 = 4'd2;

  // operand phases
  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SEG_BASE_0 = 3'd0;
  localparam logic [2:0] REG_SEG_BASE_1 = 3'd1;
  localparam logic [2:0] REG_SEG_BASE_2 = 3'd2;
  localparam logic [2:0] REG_SEG_BASE_3 = 3'd3;
  localparam logic [2:0] REG_SEG_COUNT  = 3'd4;
  localparam logic [2:0] REG_LOAD_BASE  = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] run_start;
    logic [31:0] run_count;
    logic [63:0] run_stride;
    logic [1:0]  pointer_kind;
    logic [63:0] slide_amount;
    logic        last_of_item;
  } result_t;

endpackage

>>> design/roi_if.sv
// valid/ready channels for stream bytes and result items
interface roi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface roi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] run_start;
  logic [31:0] run_count;
  logic [63:0] run_stride;
  logic [1:0]  pointer_kind;
  logic [63:0] slide_amount;
  logic        last_of_item;

  modport source (output valid, output kind, output run_start, output run_count,
                  output run_stride, output pointer_kind, output slide_amount,
                  output last_of_item, input ready);
  modport sink   (input valid, input kind, input run_start, input run_count,
                  input run_stride, input pointer_kind, input slide_amount,
                  input last_of_item, output ready);
endinterface

>>> design/rebase_opcode_interpreter.sv
// rebase opcode interpreter: byte decoder, cursor state and result queue
//
//   channel   dir   handshake      payload
//   in_i      in    valid/ready    stream_byte, end_of_stream
//   out_o     out   valid/ready    kind, run_start, run_count, run_stride,
//                                  pointer_kind, slide_amount, last_of_item
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// one byte per cycle unless the queue or the multiplier holds input back;
// a byte yields zero, one or two result items; a completed skip-run operand
// blocks input while the 32x64 cursor advance goes through the split multiplier
// results wait in a three-entry queue; input is taken while it holds at most one
// reset clears the stream state, the queue and the registers to their defaults
module rebase_opcode_interpreter
  import roi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i,
  roi_in_if.sink        in_i,
  roi_out_if.source     out_o
);

  logic [63:0] seg_base_q [SEG_SLOTS];
  logic [2:0]  seg_count_q;
  logic [63:0] load_base_q;

  logic [63:0] cursor_q, cursor_d;
  logic [3:0]  rkind_q, rkind_d;
  logic [3:0]  pend_q, pend_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  seg_q, seg_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [31:0] first_q, first_d;
  logic        stopped_q, stopped_d;

  logic        mul_a_q, mul_a_d, mul_b_q;
  logic [31:0] mul_cnt_q, mul_cnt_d;
  logic [63:0] mul_str_q, mul_str_d;
  logic [63:0] prod_lo_q;
  logic [31:0] prod_hi_q;

  result_t     ent_q [QDEPTH];
  result_t     ent_d [QDEPTH];
  logic [1:0]  cnt_q, cnt_d;

  logic        in_fire, pop;
  logic        emit_a, emit_b;
  result_t     res_a, res_b;
  logic [63:0] slide;
  logic [3:0]  op, imm;
  logic [6:0]  slice;
  logic [70:0] wide;
  logic        leb_ovf;
  logic [63:0] acc_new, leb_v;
  logic [2:0]  seg_lim;
  logic [1:0]  push_n, base;
  result_t     push0, push1;

  function automatic result_t mk_run(logic [63:0] start, logic [31:0] count,
                                     logic [63:0] stride, logic [3:0] pk,
                                     logic [63:0] sl);
    result_t r;
    r.kind         = KIND_RUN;
    r.run_start    = start;
    r.run_count    = count;
    r.run_stride   = stride;
    r.pointer_kind = pk[1:0];
    r.slide_amount = sl;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_halt(logic [1:0] k);
    result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic logic kind_ok(logic [3:0] k);
    return (k == PK_PLAIN) || (k == PK_ABS32);
  endfunction

  assign in_i.ready = (cnt_q <= 2'd1) && !mul_a_q && !mul_b_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  assign slide   = load_base_q - PREFERRED_BASE;
  assign op      = in_i.stream_byte[7:4];
  assign imm     = in_i.stream_byte[3:0];
  assign slice   = in_i.stream_byte[6:0];
  assign wide    = 71'(slice) << shift_q[5:0];
  assign leb_ovf = shift_q[6] || (|wide[70:64]);
  assign acc_new = acc_q | wide[63:0];
  assign leb_v   = acc_new;
  assign seg_lim = (seg_count_q < SEG_CAP) ? seg_count_q : SEG_CAP;

  always_comb begin
    cursor_d  = cursor_q;
    rkind_d   = rkind_q;
    pend_d    = pend_q;
    phase_d   = phase_q;
    seg_d     = seg_q;
    acc_d     = acc_q;
    shift_d   = shift_q;
    first_d   = first_q;
    stopped_d = stopped_q;
    mul_a_d   = 1'b0;
    mul_cnt_d = mul_cnt_q;
    mul_str_d = mul_str_q;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    res_a     = '0;
    res_b     = '0;

    if (in_fire) begin
      if (!stopped_q) begin
        if (phase_q == PH_OPCODE) begin
          case (op)
            OP_DONE: begin
              emit_a    = 1'b1;
              res_a     = mk_halt(KIND_FINISH);
              stopped_d = 1'b1;
            end
            OP_SET_KIND: rkind_d = imm;
            OP_SET_SEG: begin
              if ({1'b0, imm} >= {2'b0, seg_lim}) begin
                emit_a    = 1'b1;
                res_a     = mk_halt(KIND_ERROR);
                stopped_d = 1'b1;
              end else begin
                seg_d   = imm[1:0];
                pend_d  = OP_SET_SEG;
                phase_d = PH_FIRST;
              end
            end
            OP_ADD_IMM: cursor_d = cursor_q + 64'(imm) * PTR_BYTES_W;
            OP_RUN_IMM: begin
              if (imm != 4'd0 && kind_ok(rkind_q)) begin
                emit_a = 1'b1;
                res_a  = mk_run(cursor_q, 32'(imm), PTR_BYTES_W, rkind_q, slide);
              end
              cursor_d = cursor_q + 64'(imm) * PTR_BYTES_W;
            end
            OP_RUN_ADD: begin
              if (kind_ok(rkind_q)) begin
                emit_a = 1'b1;
                res_a  = mk_run(cursor_q, 32'd1, PTR_BYTES_W, rkind_q, slide);
              end
              pend_d  = OP_RUN_ADD;
              phase_d = PH_FIRST;
            end
            OP_ADD_ULEB, OP_RUN_ULEB, OP_RUN_SKIP: begin
              pend_d  = op;
              phase_d = PH_FIRST;
            end
            default: begin
              emit_a    = 1'b1;
              res_a     = mk_halt(KIND_FINISH);
              stopped_d = 1'b1;
            end
          endcase
        end else if (leb_ovf) begin
          emit_a    = 1'b1;
          res_a     = mk_halt(KIND_ERROR);
          stopped_d = 1'b1;
        end else if (in_i.stream_byte[7]) begin
          acc_d   = acc_new;
          shift_d = shift_q + 7'd7;
        end else begin
          acc_d   = '0;
          shift_d = '0;
          if (pend_q == OP_RUN_SKIP && phase_q == PH_FIRST) begin
            if (leb_v > COUNT_MAX) begin
              emit_a    = 1'b1;
              res_a     = mk_halt(KIND_ERROR);
              stopped_d = 1'b1;
            end else begin
              first_d = leb_v[31:0];
              phase_d = PH_SECOND;
            end
          end else if (pend_q == OP_RUN_SKIP) begin
            phase_d = PH_OPCODE;
            if (first_q != 32'd0 && kind_ok(rkind_q)) begin
              emit_a = 1'b1;
              res_a  = mk_run(cursor_q, first_q, leb_v + PTR_BYTES_W, rkind_q, slide);
            end
            mul_a_d   = 1'b1;
            mul_cnt_d = first_q;
            mul_str_d = leb_v + PTR_BYTES_W;
          end else begin
            phase_d = PH_OPCODE;
            case (pend_q)
              OP_SET_SEG:  cursor_d = seg_base_q[seg_q] + leb_v;
              OP_ADD_ULEB: cursor_d = cursor_q + leb_v;
              OP_RUN_ULEB: begin
                if (leb_v > COUNT_MAX) begin
                  emit_a    = 1'b1;
                  res_a     = mk_halt(KIND_ERROR);
                  stopped_d = 1'b1;
                end else begin
                  if (leb_v != 64'd0 && kind_ok(rkind_q)) begin
                    emit_a = 1'b1;
                    res_a  = mk_run(cursor_q, leb_v[31:0], PTR_BYTES_W, rkind_q, slide);
                  end
                  cursor_d = cursor_q + leb_v * PTR_BYTES_W;
                end
              end
              OP_RUN_ADD:  cursor_d = cursor_q + leb_v + PTR_BYTES_W;
              default: ;
            endcase
          end
        end
      end

      if (in_i.end_of_stream) begin
        if (!stopped_d) begin
          emit_b = 1'b1;
          res_b  = mk_halt((phase_d != PH_OPCODE) ? KIND_ERROR : KIND_FINISH);
        end
        cursor_d  = '0;
        rkind_d   = PK_PLAIN;
        pend_d    = OP_DONE;
        phase_d   = PH_OPCODE;
        seg_d     = '0;
        acc_d     = '0;
        shift_d   = '0;
        first_d   = '0;
        stopped_d = 1'b0;
        mul_a_d   = 1'b0;
      end
    end

    if (mul_b_q) begin
      cursor_d = cursor_q + prod_lo_q + {prod_hi_q, 32'd0};
    end
  end

  // result queue
  always_comb begin
    push_n = 2'(emit_a) + 2'(emit_b);
    push0  = emit_a ? res_a : res_b;
    push1  = res_b;
    if (push_n == 2'd1) begin
      push0.last_of_item = 1'b1;
    end
    push1.last_of_item = 1'b1;
    base = cnt_q - 2'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_n != 2'd0 && 2'(i) == base) begin
        ent_d[i] = push0;
      end
      if (push_n == 2'd2 && 2'(i) == base + 2'd1) begin
        ent_d[i] = push1;
      end
    end
    cnt_d = base + push_n;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
    mul_cnt_q <= mul_cnt_d;
    mul_str_q <= mul_str_d;
    if (mul_a_q) begin
      prod_lo_q <= 64'(mul_cnt_q) * 64'(mul_str_q[31:0]);
      prod_hi_q <= 32'(64'(mul_cnt_q) * 64'(mul_str_q[63:32]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEG_SLOTS; i++) begin
        seg_base_q[i] <= '0;
      end
      seg_count_q <= '0;
      load_base_q <= PREFERRED_BASE;
      cursor_q    <= '0;
      rkind_q     <= PK_PLAIN;
      pend_q      <= OP_DONE;
      phase_q     <= PH_OPCODE;
      seg_q       <= '0;
      acc_q       <= '0;
      shift_q     <= '0;
      first_q     <= '0;
      stopped_q   <= 1'b0;
      mul_a_q     <= 1'b0;
      mul_b_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEG_BASE_0: seg_base_q[0] <= cfg_wdata_i;
          REG_SEG_BASE_1: seg_base_q[1] <= cfg_wdata_i;
          REG_SEG_BASE_2: seg_base_q[2] <= cfg_wdata_i;
          REG_SEG_BASE_3: seg_base_q[3] <= cfg_wdata_i;
          REG_SEG_COUNT:  seg_count_q   <= cfg_wdata_i[2:0];
          REG_LOAD_BASE:  load_base_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      cursor_q  <= cursor_d;
      rkind_q   <= rkind_d;
      pend_q    <= pend_d;
      phase_q   <= phase_d;
      seg_q     <= seg_d;
      acc_q     <= acc_d;
      shift_q   <= shift_d;
      first_q   <= first_d;
      stopped_q <= stopped_d;
      mul_a_q   <= mul_a_d;
      mul_b_q   <= mul_a_q;
      cnt_q     <= cnt_d;
    end
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.kind         = ent_q[0].kind;
  assign out_o.run_start    = ent_q[0].run_start;
  assign out_o.run_count    = ent_q[0].run_count;
  assign out_o.run_stride   = ent_q[0].run_stride;
  assign out_o.pointer_kind = ent_q[0].pointer_kind;
  assign out_o.slide_amount = ent_q[0].slide_amount;
  assign out_o.last_of_item = ent_q[0].last_of_item;

endmodule

>>> test/rebase_opcode_interpreter_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the rebase opcode interpreter: driver, monitor, predictor
module rebase_opcode_interpreter_test;
  import roi_pkg::*;

  localparam logic [3:0] OP_FIRST_UNKNOWN = 4'd9;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } stream_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  roi_in_if  in_ch ();
  roi_out_if out_ch ();

  rebase_opcode_interpreter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  stream_item_t byte_q [$];
  result_t      exp_descr_q [$];
  int           fail_count = 0;
  int           bytes_taken = 0;
  int           idle_rate = 8;
  int           send_gap = 0;
  int           hold_cnt = 0;
  bit           long_hold_done = 0;

  // predictor copy of the registers
  logic [63:0] cfg_seg_base [4];
  logic [2:0]  cfg_seg_count;
  logic [63:0] cfg_load_base;

  // predictor copy of the stream state
  logic [63:0] cursor;
  logic [3:0]  ptr_kind;
  logic [3:0]  wait_op;
  logic [1:0]  phase;
  logic [1:0]  seg_sel;
  logic [63:0] leb_val;
  int          leb_pos;
  logic [63:0] skip_count;
  bit          halted;
  int          n_new;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------- predictor ----------------

  task automatic clear_stream();
    cursor     = '0;
    ptr_kind   = PK_PLAIN;
    wait_op    = OP_DONE;
    phase      = PH_OPCODE;
    seg_sel    = '0;
    leb_val    = '0;
    leb_pos    = 0;
    skip_count = '0;
    halted     = 0;
  endtask

  task automatic add_result(logic [1:0] k, logic [63:0] start, logic [63:0] count,
                            logic [63:0] stride, logic [1:0] pk, logic [63:0] slide);
    result_t r;
    r.kind         = k;
    r.run_start    = start;
    r.run_count    = count[31:0];
    r.run_stride   = stride;
    r.pointer_kind = pk;
    r.slide_amount = slide;
    r.last_of_item = 1'b0;
    exp_descr_q.push_back(r);
    n_new++;
  endtask

  task automatic stop_stream(logic [1:0] k);
    add_result(k, '0, '0, '0, '0, '0);
    halted = 1;
  endtask

  task automatic patch_run(logic [63:0] count, logic [63:0] stride);
    if (count != 0 && (ptr_kind == PK_PLAIN || ptr_kind == PK_ABS32))
      add_result(KIND_RUN, cursor, count, stride, ptr_kind[1:0],
                 cfg_load_base - PREFERRED_BASE);
    cursor = cursor + count * stride;
  endtask

  task automatic take_opcode(logic [7:0] b);
    logic [3:0] imm;
    logic [2:0] lim;
    imm = b[3:0];
    lim = (cfg_seg_count < SEG_CAP) ? cfg_seg_count : SEG_CAP;
    case (b[7:4])
      OP_DONE:     stop_stream(KIND_FINISH);
      OP_SET_KIND: ptr_kind = imm;
      OP_SET_SEG: begin
        if (imm >= {1'b0, lim}) begin
          stop_stream(KIND_ERROR);
        end else begin
          seg_sel = imm[1:0];
          wait_op = OP_SET_SEG;
          phase   = PH_FIRST;
        end
      end
      OP_ADD_IMM:  cursor = cursor + 64'(imm) * PTR_BYTES_W;
      OP_RUN_IMM:  patch_run(64'(imm), PTR_BYTES_W);
      OP_RUN_ADD: begin
        if (ptr_kind == PK_PLAIN || ptr_kind == PK_ABS32)
          add_result(KIND_RUN, cursor, 64'd1, PTR_BYTES_W, ptr_kind[1:0],
                     cfg_load_base - PREFERRED_BASE);
        wait_op = OP_RUN_ADD;
        phase   = PH_FIRST;
      end
      OP_ADD_ULEB, OP_RUN_ULEB, OP_RUN_SKIP: begin
        wait_op = b[7:4];
        phase   = PH_FIRST;
      end
      default:     stop_stream(KIND_FINISH);
    endcase
  endtask

  task automatic take_operand(logic [7:0] b);
    logic [63:0] slice;
    logic [63:0] v;
    slice = {57'b0, b[6:0]};
    if (leb_pos >= 64 || (leb_pos > 0 && (slice >> (64 - leb_pos)) != 0)) begin
      stop_stream(KIND_ERROR);
    end else begin
      leb_val = leb_val | (slice << leb_pos);
      leb_pos = leb_pos + 7;
      if (!b[7]) begin
        v       = leb_val;
        leb_val = '0;
        leb_pos = 0;
        if (wait_op == OP_RUN_SKIP && phase == PH_FIRST) begin
          if (v > COUNT_MAX) begin
            stop_stream(KIND_ERROR);
          end else begin
            skip_count = v;
            phase      = PH_SECOND;
          end
        end else begin
          phase = PH_OPCODE;
          case (wait_op)
            OP_SET_SEG:  cursor = cfg_seg_base[seg_sel] + v;
            OP_ADD_ULEB: cursor = cursor + v;
            OP_RUN_ULEB: begin
              if (v > COUNT_MAX) stop_stream(KIND_ERROR);
              else patch_run(v, PTR_BYTES_W);
            end
            OP_RUN_ADD:  cursor = cursor + v + PTR_BYTES_W;
            OP_RUN_SKIP: patch_run(skip_count, v + PTR_BYTES_W);
            default: ;
          endcase
        end
      end
    end
  endtask

  task automatic decode_stream_byte(logic [7:0] b, logic eos);
    result_t r;
    n_new = 0;
    if (!halted) begin
      if (phase == PH_OPCODE) take_opcode(b);
      else take_operand(b);
    end
    if (eos) begin
      if (!halted) stop_stream((phase != PH_OPCODE) ? KIND_ERROR : KIND_FINISH);
      clear_stream();
    end
    if (n_new > 0) begin
      r = exp_descr_q.pop_back();
      r.last_of_item = 1'b1;
      exp_descr_q.push_back(r);
    end
  endtask

  // ---------------- driver and monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin : feed
    stream_item_t it;
    bit go;
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.stream_byte   <= '0;
      in_ch.end_of_stream <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      go = 0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (byte_q.size() > 0) begin
        if (idle_rate != 0 && $urandom_range(0, idle_rate - 1) == 0)
          send_gap = $urandom_range(0, 18);
        else
          go = 1;
      end
      if (go) begin
        it = byte_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.stream_byte   <= it.data;
        in_ch.end_of_stream <= it.eos;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drain_side
    bit r;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      r = 0;
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (!long_hold_done && bytes_taken >= 300) begin
        // long hold-off so the result queue fills and input backs up
        long_hold_done = 1;
        hold_cnt = 400;
      end else if (idle_rate != 0 && $urandom_range(0, idle_rate - 1) == 0) begin
        hold_cnt = $urandom_range(0, 18);
      end else begin
        r = 1;
      end
      out_ch.ready <= r;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : observe
    result_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_stream_byte(in_ch.stream_byte, in_ch.end_of_stream);
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exp_descr_q.size() == 0) begin
          $error("result item with none expected: kind %0d start %h", out_ch.kind,
                 out_ch.run_start);
          fail_count++;
        end else begin
          want = exp_descr_q.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("run_start", want.run_start, out_ch.run_start);
          check_field("run_count", want.run_count, out_ch.run_count);
          check_field("run_stride", want.run_stride, out_ch.run_stride);
          check_field("pointer_kind", want.pointer_kind, out_ch.pointer_kind);
          check_field("slide_amount", want.slide_amount, out_ch.slide_amount);
          check_field("last_of_item", want.last_of_item, out_ch.last_of_item);
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic set_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_SEG_COUNT) cfg_seg_count = val[2:0];
    else if (idx == REG_LOAD_BASE) cfg_load_base = val;
    else cfg_seg_base[idx[1:0]] = val;
  endtask

  task automatic program_regs(logic [63:0] b0, logic [63:0] b1, logic [63:0] b2,
                              logic [63:0] b3, logic [2:0] count, logic [63:0] load);
    set_reg(REG_SEG_BASE_0, b0);
    set_reg(REG_SEG_BASE_1, b1);
    set_reg(REG_SEG_BASE_2, b2);
    set_reg(REG_SEG_BASE_3, b3);
    set_reg(REG_SEG_COUNT, 64'(count));
    set_reg(REG_LOAD_BASE, load);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || in_ch.valid || exp_descr_q.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic put(logic [7:0] b);
    byte_q.push_back({b, 1'b0});
  endtask

  task automatic mark_end();
    stream_item_t it;
    it = byte_q.pop_back();
    it.eos = 1'b1;
    byte_q.push_back(it);
  endtask

  function automatic logic [63:0] any_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'($urandom_range(1, 255));
      2:       return 64'($urandom);
      5:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] any_count();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return COUNT_MAX;
      2:       return 64'($urandom);
      3:       return {32'($urandom_range(1, 15)), 32'($urandom)};
      default: return 64'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic put_uleb(logic [63:0] v);
    logic [7:0] enc [$];
    logic [63:0] x;
    int pad;
    if ($urandom_range(0, 39) == 0) begin
      // overlong or overflowing encoding
      repeat (9) put(8'h80 | 8'($urandom_range(0, 127)));
      if ($urandom_range(0, 1) == 0) begin
        put(8'h80 | 8'($urandom_range(0, 1)));
        put(8'($urandom));
      end else begin
        put({1'($urandom), 7'($urandom_range(2, 127))});
      end
    end else begin
      x = v;
      do begin
        enc.push_back({(x >> 7) != 0, x[6:0]});
        x = x >> 7;
      end while (x != 0);
      pad = 0;
      if (enc.size() < 10 && $urandom_range(0, 7) == 0)
        pad = $urandom_range(1, 10 - enc.size());
      if (pad > 0) begin
        enc[enc.size() - 1] = enc[enc.size() - 1] | 8'h80;
        repeat (pad - 1) enc.push_back(8'h80);
        enc.push_back(8'h00);
      end
      foreach (enc[i]) put(enc[i]);
    end
  endtask

  task automatic gen_stream();
    int sel;
    int ending;
    logic [3:0] op;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 10)) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          put({OP_SET_KIND, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 2))});
        end else if (sel < 22) begin
          put({OP_SET_SEG, ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, 3))});
          put_uleb(any_value());
        end else if (sel < 32) begin
          put({OP_ADD_ULEB, 4'($urandom)});
          put_uleb(any_value());
        end else if (sel < 40) begin
          put({OP_ADD_IMM, 4'($urandom)});
        end else if (sel < 55) begin
          put({OP_RUN_IMM, 4'($urandom)});
        end else if (sel < 68) begin
          put({OP_RUN_ULEB, 4'($urandom)});
          put_uleb(any_count());
        end else if (sel < 80) begin
          put({OP_RUN_ADD, 4'($urandom)});
          put_uleb(any_value());
        end else if (sel < 95) begin
          put({OP_RUN_SKIP, 4'($urandom)});
          put_uleb(any_count());
          put_uleb(any_value());
        end else begin
          put(8'($urandom));
        end
      end
      ending = $urandom_range(0, 9);
      if (ending == 7) begin
        // stream cut off inside an operand
        case ($urandom_range(0, 3))
          0:       op = OP_ADD_ULEB;
          1:       op = OP_RUN_ULEB;
          2:       op = OP_RUN_SKIP;
          default: op = OP_RUN_ADD;
        endcase
        put({op, 4'($urandom)});
        repeat ($urandom_range(0, 3)) put(8'h80 | 8'($urandom_range(0, 127)));
      end else if (ending == 4 || ending == 5) begin
        put({OP_DONE, 4'($urandom)});
        repeat ($urandom_range(0, 3)) put(8'($urandom));
      end else if (ending == 6) begin
        put({4'($urandom_range(OP_FIRST_UNKNOWN, 15)), 4'($urandom)});
        repeat ($urandom_range(0, 2)) put(8'($urandom));
      end
    end
    mark_end();
  endtask

  task automatic fill_streams(int n);
    while (byte_q.size() < n) gen_stream();
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_SEG_BASE_0;
    cfg_wdata_i         <= '0;
    foreach (cfg_seg_base[i]) cfg_seg_base[i] = '0;
    cfg_seg_count = '0;
    cfg_load_base = PREFERRED_BASE;
    clear_stream();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed streams
    program_regs(64'h1000, '1, {$urandom, $urandom}, '0, 3'd4, 64'h1_2000_0000);
    put({OP_SET_KIND, PK_PLAIN});
    put({OP_SET_SEG, 4'd1});
    put(8'h10);
    put({OP_RUN_IMM, 4'd3});
    put({OP_ADD_IMM, 4'd15});
    put({OP_RUN_ULEB, 4'd0});
    repeat (4) put(8'hFF);
    put(8'h0F);
    put({OP_SET_KIND, PK_ABS32});
    put({OP_RUN_ADD, 4'd0});
    put(8'h05);
    put({OP_RUN_SKIP, 4'd0});
    put(8'h02);
    put(8'h03);
    put({OP_SET_KIND, 4'd3});
    put({OP_RUN_IMM, 4'd2});
    put({OP_DONE, 4'd0});
    mark_end();
    put({OP_SET_SEG, 4'd5});
    mark_end();
    put({OP_FIRST_UNKNOWN, 4'd10});
    put({OP_SET_KIND, PK_PLAIN});
    mark_end();
    put({OP_ADD_ULEB, 4'd0});
    put(8'h80);
    mark_end();
    put({OP_RUN_ULEB, 4'd0});
    repeat (4) put(8'h80);
    put(8'h10);
    put({OP_RUN_IMM, 4'd5});
    mark_end();
    settle();

    // no valid segment, zero load base
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 3'd0, '0);
    fill_streams(140);
    settle();

    idle_rate = 4;
    program_regs('0, '1, {$urandom, $urandom}, {$urandom, $urandom}, 3'd4, '1);
    fill_streams(250);
    settle();

    idle_rate = 16;
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 3'($urandom_range(1, 3)), {$urandom, $urandom});
    fill_streams(250);
    settle();

    // closing stretch without idling
    idle_rate = 0;
    program_regs({$urandom, $urandom}, 64'($urandom), '1, {$urandom, $urandom}, 3'd4,
                 PREFERRED_BASE + 64'($urandom));
    fill_streams(250);
    settle();

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
